FILE: src/glos_pkg.sv
package glos_pkg;

    localparam int MAP_DIM     = 64;
    localparam int TILE_BITS   = 6;
    localparam int FIELD_W     = 6;
    localparam int MASK_W      = 64;
    localparam int COORD_W     = $clog2(MAP_DIM);
    localparam int CELL_COUNT  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int ERR_W       = COORD_W + 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_REJECT = 2'd2;

    // bound for grid coordinates, one bit wider than an input field
    localparam logic [FIELD_W:0] DIM_LIMIT = (FIELD_W + 1)'(MAP_DIM);

    typedef struct packed {
        logic [1:0]           kind;
        logic [COORD_W-1:0]   ax;
        logic [COORD_W-1:0]   ay;
        logic [COORD_W-1:0]   bx;
        logic [COORD_W-1:0]   by;
        logic [TILE_BITS-1:0] code;
        logic [COORD_W-1:0]   dx;
        logic [COORD_W-1:0]   dy;
        logic                 sx;
        logic                 sy;
    } glos_cmd_t;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(y) * ADDR_W'(MAP_DIM) + ADDR_W'(x);
        return a;
    endfunction

endpackage

FILE: src/glos_front.sv
module glos_front (
    input  logic                           start,
    input  logic                           full,
    input  logic                           action,
    input  logic [glos_pkg::FIELD_W-1:0]   cell_x,
    input  logic [glos_pkg::FIELD_W-1:0]   cell_y,
    input  logic [glos_pkg::FIELD_W-1:0]   tile_code,
    input  logic [glos_pkg::FIELD_W-1:0]   from_x,
    input  logic [glos_pkg::FIELD_W-1:0]   from_y,
    input  logic [glos_pkg::FIELD_W-1:0]   to_x,
    input  logic [glos_pkg::FIELD_W-1:0]   to_y,
    output logic                           push,
    output glos_pkg::glos_cmd_t            cmd
);

    logic write_off;
    logic query_off;
    logic [glos_pkg::COORD_W-1:0] ax;
    logic [glos_pkg::COORD_W-1:0] ay;
    logic [glos_pkg::COORD_W-1:0] bx;
    logic [glos_pkg::COORD_W-1:0] by;

    assign write_off = ({1'b0, cell_x} >= glos_pkg::DIM_LIMIT)
                    || ({1'b0, cell_y} >= glos_pkg::DIM_LIMIT);
    assign query_off = ({1'b0, from_x} >= glos_pkg::DIM_LIMIT)
                    || ({1'b0, from_y} >= glos_pkg::DIM_LIMIT)
                    || ({1'b0, to_x} >= glos_pkg::DIM_LIMIT)
                    || ({1'b0, to_y} >= glos_pkg::DIM_LIMIT);

    assign ax = glos_pkg::COORD_W'(from_x);
    assign ay = glos_pkg::COORD_W'(from_y);
    assign bx = glos_pkg::COORD_W'(to_x);
    assign by = glos_pkg::COORD_W'(to_y);

    // writes off the grid are dropped here and never reach the queue
    assign push = start && !full && !(action == glos_pkg::ACT_WRITE && write_off);

    always_comb
    begin
        cmd = '0;
        if (action == glos_pkg::ACT_WRITE)
        begin
            cmd.kind = glos_pkg::CMD_WRITE;
            cmd.ax   = glos_pkg::COORD_W'(cell_x);
            cmd.ay   = glos_pkg::COORD_W'(cell_y);
            cmd.code = tile_code[glos_pkg::TILE_BITS-1:0];
        end
        else
        begin
            cmd.kind = query_off ? glos_pkg::CMD_REJECT : glos_pkg::CMD_QUERY;
            cmd.ax   = ax;
            cmd.ay   = ay;
            cmd.bx   = bx;
            cmd.by   = by;
            cmd.dx   = (bx > ax) ? bx - ax : ax - bx;
            cmd.dy   = (by > ay) ? by - ay : ay - by;
            cmd.sx   = ax < bx;
            cmd.sy   = ay < by;
        end
    end

endmodule

FILE: src/glos_queue.sv
module glos_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  glos_pkg::glos_cmd_t  push_cmd,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output glos_pkg::glos_cmd_t  head
);

    glos_pkg::glos_cmd_t slot_reg [glos_pkg::QUEUE_DEPTH];

    logic [glos_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [glos_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [glos_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [glos_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [glos_pkg::QCNT_W-1:0] count_reg;
    logic [glos_pkg::QCNT_W-1:0] count_next;

    assign full       = count_reg == glos_pkg::QCNT_W'(glos_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == glos_pkg::QPTR_W'(glos_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == glos_pkg::QPTR_W'(glos_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

FILE: src/glos_ram.sv
module glos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

FILE: src/glos_back.sv
module glos_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  glos_pkg::glos_cmd_t          head,
    input  logic [glos_pkg::MASK_W-1:0]  wall_code_mask,
    output logic                         pop,
    output logic                         done,
    output logic                         sight_clear
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;
    logic pend_reg;
    logic pend_next;
    logic done_reg;
    logic done_next;
    logic clear_reg;
    logic clear_next;

    logic [glos_pkg::COORD_W-1:0] cx_reg;
    logic [glos_pkg::COORD_W-1:0] cx_next;
    logic [glos_pkg::COORD_W-1:0] cy_reg;
    logic [glos_pkg::COORD_W-1:0] cy_next;
    logic [glos_pkg::COORD_W-1:0] ax_reg;
    logic [glos_pkg::COORD_W-1:0] ay_reg;
    logic [glos_pkg::COORD_W-1:0] bx_reg;
    logic [glos_pkg::COORD_W-1:0] by_reg;
    logic [glos_pkg::COORD_W-1:0] dx_reg;
    logic [glos_pkg::COORD_W-1:0] dy_reg;
    logic                         sx_reg;
    logic                         sy_reg;
    logic signed [glos_pkg::ERR_W-1:0] err_reg;
    logic signed [glos_pkg::ERR_W-1:0] err_next;

    logic signed [glos_pkg::ERR_W:0]   twice;
    logic signed [glos_pkg::ERR_W:0]   dx_ext;
    logic signed [glos_pkg::ERR_W:0]   dy_ext;
    logic step_x;
    logic step_y;
    logic at_end;
    logic at_start;
    logic hit;
    logic load;

    logic                              ram_we;
    logic [glos_pkg::ADDR_W-1:0]       ram_waddr;
    logic [glos_pkg::ADDR_W-1:0]       ram_raddr;
    logic [glos_pkg::TILE_BITS-1:0]    ram_rdata;

    glos_ram #(
        .WIDTH (glos_pkg::TILE_BITS),
        .DEPTH (glos_pkg::CELL_COUNT)
    ) u_tiles (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (head.code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop       = (state_reg == ST_IDLE) && head_valid;
    assign ram_we    = pop && (head.kind == glos_pkg::CMD_WRITE);
    assign ram_waddr = glos_pkg::cell_addr(head.ax, head.ay);
    assign ram_raddr = glos_pkg::cell_addr(cx_reg, cy_reg);
    assign load      = pop && (head.kind == glos_pkg::CMD_QUERY);

    assign at_end   = (cx_reg == bx_reg) && (cy_reg == by_reg);
    assign at_start = (cx_reg == ax_reg) && (cy_reg == ay_reg);
    // read data belongs to the cell looked up in the previous cycle
    assign hit      = pend_reg && wall_code_mask[ram_rdata];

    assign twice  = {err_reg, 1'b0};
    assign dx_ext = $signed({3'b000, dx_reg, 1'b0}) >>> 1;
    assign dy_ext = $signed({3'b000, dy_reg, 1'b0}) >>> 1;
    assign step_x = twice > -dy_ext;
    assign step_y = twice < dx_ext;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        clear_next = clear_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.kind == glos_pkg::CMD_REJECT)
                begin
                    done_next  = 1'b1;
                    clear_next = 1'b0;
                end
                else if (load)
                begin
                    state_next = ST_WALK;
                    cx_next    = head.ax;
                    cy_next    = head.ay;
                    err_next   = glos_pkg::ERR_W'($signed({3'b000, head.dx}))
                               - glos_pkg::ERR_W'($signed({3'b000, head.dy}));
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    clear_next = 1'b0;
                end
                else if (at_end)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    clear_next = 1'b1;
                end
                else
                begin
                    pend_next = !at_start;
                    err_next  = err_reg
                              - (step_x ? glos_pkg::ERR_W'(dy_ext) : '0)
                              + (step_y ? glos_pkg::ERR_W'(dx_ext) : '0);
                    if (step_x)
                    begin
                        cx_next = sx_reg ? cx_reg + 1'b1 : cx_reg - 1'b1;
                    end
                    if (step_y)
                    begin
                        cy_next = sy_reg ? cy_reg + 1'b1 : cy_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clear_reg <= clear_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        err_reg   <= err_next;
        if (load)
        begin
            ax_reg <= head.ax;
            ay_reg <= head.ay;
            bx_reg <= head.bx;
            by_reg <= head.by;
            dx_reg <= head.dx;
            dy_reg <= head.dy;
            sx_reg <= head.sx;
            sy_reg <= head.sy;
        end
    end

    assign done        = done_reg;
    assign sight_clear = clear_reg;

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE)
        else $error("tile write while a walk is running");

    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_WALK)
        else $error("cell check pending outside a walk");

    a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && at_end && !hit) |=> done_reg && clear_reg)
        else $error("walk reached its end cell without a clear result");

    a_hit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && hit) |=> done_reg && !clear_reg)
        else $error("wall seen but result not blocked");

endmodule

FILE: src/grid_line_of_sight_top.sv
// line-of-sight checker over a 64 x 64 grid of tile codes
//
// requests enter on start when busy is low; action selects a tile write
// (cell_x, cell_y, tile_code) or a query (from_x, from_y, to_x, to_y).
// requests pass through a two-entry queue, so start is taken while the
// walker is still busy with an earlier query; busy rises only when it fills.
// a write waits in the queue and reaches the tile memory once the walker
// is idle and pops it, and gives no result.
// a query gives one result on sight_clear, marked by a one-cycle done pulse.
// the walker steps one cell per cycle through the single read port of the
// tile memory, and takes the next request from the queue only when idle.
// wall_code_mask is written through cfg_valid / cfg_ready (always ready);
// the user must write it only while the block is idle, which the block
// itself does not enforce; bit k marks tile code k as a wall.
// the result side cannot stall: done is a pulse the receiver must take.
// reset clears the queue, the walker and the mask; the tile memory is not
// cleared and cells must be written before a query reads them.
module grid_line_of_sight_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [glos_pkg::FIELD_W-1:0]   cell_x,
    input  logic [glos_pkg::FIELD_W-1:0]   cell_y,
    input  logic [glos_pkg::FIELD_W-1:0]   tile_code,
    input  logic [glos_pkg::FIELD_W-1:0]   from_x,
    input  logic [glos_pkg::FIELD_W-1:0]   from_y,
    input  logic [glos_pkg::FIELD_W-1:0]   to_x,
    input  logic [glos_pkg::FIELD_W-1:0]   to_y,
    output logic                           done,
    output logic                           sight_clear,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [glos_pkg::MASK_W-1:0]    wall_code_mask
);

    logic [glos_pkg::MASK_W-1:0] wall_code_mask_reg;

    logic                full;
    logic                push;
    logic                pop;
    logic                head_valid;
    glos_pkg::glos_cmd_t push_cmd;
    glos_pkg::glos_cmd_t head;

    assign cfg_ready = 1'b1;
    assign busy      = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_code_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            wall_code_mask_reg <= wall_code_mask;
        end
    end

    glos_front u_front (
        .start     (start),
        .full      (full),
        .action    (action),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .tile_code (tile_code),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .push      (push),
        .cmd       (push_cmd)
    );

    glos_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    glos_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .wall_code_mask (wall_code_mask_reg),
        .pop            (pop),
        .done           (done),
        .sight_clear    (sight_clear)
    );

endmodule
